FILE: hw/rtl/acis_pkg.sv
// shared types and constants for the annulus cone isolation sum unit
package acis_pkg;

  localparam int ANGLE_FRAC_BITS = 10;
  localparam int ENERGY_WIDTH    = 16;
  localparam int MAX_TOWERS_LOG2 = 12;

  // pi in angle units, rounded to nearest from a q30 value
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int PI_FX     = int'((PI_Q30 + (64'd1 << (29 - ANGLE_FRAC_BITS)))
                                  >> (30 - ANGLE_FRAC_BITS));
  localparam int TWO_PI_FX = 2 * PI_FX;

  // field widths
  localparam int ETA_W      = 14;
  localparam int PHI_W      = 13;
  localparam int RADIUS_W   = 12;
  localparam int PT_W       = 16;
  localparam int ET_W       = 16;
  localparam int OUT_SUM_W  = 28;
  localparam int RATIO_W    = 24;
  localparam int RATIO_FRAC = 16;

  // internal widths
  localparam int DETA_W    = ETA_W + 1;
  localparam int DPHI_W    = PHI_W - 1;
  localparam int DETA_SQ_W = 2 * DETA_W - 2;
  localparam int DPHI_SQ_W = 2 * DPHI_W;
  localparam int RAD_SQ_W  = 2 * RADIUS_W;
  localparam int DR2_W     = DETA_SQ_W + 1;
  localparam int SUM_W     = MAX_TOWERS_LOG2 + ENERGY_WIDTH;
  localparam int RQ_SHIFT  = RATIO_W - RATIO_FRAC;

  // port packing
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 2 * OUT_SUM_W + 2 * RATIO_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_ETA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_PHI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ELECTRON_PT  = 3'd4;

  // queue between classifier and accumulator
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // divider
  localparam int DIV_STEPS = RATIO_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [ETA_W-1:0] ceta;
    logic [PHI_W-1:0]        cphi_w;
    logic [RAD_SQ_W-1:0]     outer_sq;
    logic [RAD_SQ_W-1:0]     inner_sq;
  } acis_geom_t;

  typedef struct packed {
    logic [ENERGY_WIDTH-1:0] had;
    logic [ENERGY_WIDTH-1:0] em;
    logic                    last;
  } acis_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } acis_div_ctl_t;

endpackage

FILE: hw/rtl/annulus_cone_isolation_sum_unit.sv
// top level: configuration registers, classifier, tower queue and accumulator
// path to out_tvalid: the last tower accepted passes the remaining classifier stages,
//   the queue write, one accumulate, 24 divider steps and the result load
// throughput: one tower per cycle inside a pass; closing a pass stops the accumulator for the
//   24 divider steps and the result load, the input stalls once the 8-word queue fills
// reset: synchronous active-low rst_n clears configuration registers, control state, accumulators and queue
module annulus_cone_isolation_sum_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // tower_eta[13:0], tower_phi[26:14], had_et[42:27], em_et[58:43], zero fill
  input  logic [acis_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // had_sum[27:0], em_sum[55:28], had_ratio[79:56], em_ratio[103:80]
  output logic [acis_pkg::OUT_DATA_W-1:0]    out_tdata,
  // pt_zero[0]
  output logic                               out_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [acis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [acis_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import acis_pkg::*;

  logic signed [ETA_W-1:0] ceta_r;
  logic [PHI_W-1:0]        cphi_w_r;
  logic [RAD_SQ_W-1:0]     outer_sq_r;
  logic [RAD_SQ_W-1:0]     inner_sq_r;
  logic [PT_W-1:0]         pt_r;

  logic                    cfg_we;
  logic signed [PHI_W:0]   cphi_ext;
  logic signed [PHI_W:0]   cphi_wrap;
  logic [RADIUS_W-1:0]     radius;
  logic [RAD_SQ_W-1:0]     radius_sq;
  acis_geom_t              geom;

  logic                    push, pop, empty;
  acis_item_t              push_item, head;
  logic [FIFO_CW-1:0]      fifo_count;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cphi_ext  = {cfg_data[PHI_W-1], cfg_data[PHI_W-1:0]};
    cphi_wrap = cfg_data[PHI_W-1] ? cphi_ext + (PHI_W + 1)'(TWO_PI_FX) : cphi_ext;
    radius    = cfg_data[RADIUS_W-1:0];
    radius_sq = radius * radius;
  end

  // centre phi is kept already wrapped into 0..2pi, radii kept squared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceta_r     <= '0;
      cphi_w_r   <= '0;
      outer_sq_r <= '0;
      inner_sq_r <= '0;
      pt_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTRE_ETA:   ceta_r     <= cfg_data[ETA_W-1:0];
        REG_CENTRE_PHI:   cphi_w_r   <= cphi_wrap[PHI_W-1:0];
        REG_OUTER_RADIUS: outer_sq_r <= radius_sq;
        REG_INNER_RADIUS: inner_sq_r <= radius_sq;
        REG_ELECTRON_PT:  pt_r       <= cfg_data[PT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.ceta     = ceta_r;
    geom.cphi_w   = cphi_w_r;
    geom.outer_sq = outer_sq_r;
    geom.inner_sq = inner_sq_r;
  end

  acis_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .tower_eta  (in_tdata[13:0]),
    .tower_phi  (in_tdata[26:14]),
    .had_et     (in_tdata[42:27]),
    .em_et      (in_tdata[58:43]),
    .last_tower (in_tlast),
    .geom       (geom),
    .fifo_count (fifo_count),
    .push       (push),
    .push_item  (push_item)
  );

  acis_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .count     (fifo_count)
  );

  acis_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .electron_pt (pt_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

FILE: hw/rtl/acis_front.sv
// tower classifier: phi wrap and fold, squared distance, annulus test
module acis_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [acis_pkg::ETA_W-1:0] tower_eta,
  input  logic signed [acis_pkg::PHI_W-1:0] tower_phi,
  input  logic [acis_pkg::ET_W-1:0]         had_et,
  input  logic [acis_pkg::ET_W-1:0]         em_et,
  input  logic                              last_tower,
  input  acis_pkg::acis_geom_t              geom,
  input  logic [acis_pkg::FIFO_CW-1:0]      fifo_count,
  output logic                              push,
  output acis_pkg::acis_item_t              push_item
);
  import acis_pkg::*;

  logic                    v1_r, v2_r, v3_r;
  logic [PHI_W-1:0]        tphi_w_r;
  logic signed [DETA_W-1:0] deta1_r, deta2_r;
  logic [DPHI_W-1:0]       dphi_r;
  logic [DETA_SQ_W-1:0]    deta_sq_r;
  logic [DPHI_SQ_W-1:0]    dphi_sq_r;
  acis_item_t              it1_r, it2_r, it3_r;

  logic                    accept;
  logic signed [PHI_W:0]   tphi_ext;
  logic signed [PHI_W:0]   tphi_wrap;
  logic signed [DETA_W-1:0] deta;
  logic signed [PHI_W:0]   dphi_diff;
  logic signed [PHI_W:0]   dphi_mag;
  logic [PHI_W-1:0]        dphi_abs;
  logic [PHI_W-1:0]        dphi_fold;
  logic signed [2*DETA_W-1:0] deta_prod;
  logic [DR2_W-1:0]        dr2;
  logic                    hit;
  logic [2:0]              inflight;

  // every accepted word is guaranteed a queue slot
  assign inflight = {2'b0, v1_r} + {2'b0, v2_r} + {2'b0, v3_r};
  assign in_ready = ({1'b0, fifo_count} + (FIFO_CW + 1)'(inflight))
                    < (FIFO_CW + 1)'(FIFO_DEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    tphi_ext  = {tower_phi[PHI_W-1], tower_phi};
    tphi_wrap = tower_phi[PHI_W-1] ? tphi_ext + (PHI_W + 1)'(TWO_PI_FX) : tphi_ext;
    deta      = {tower_eta[ETA_W-1], tower_eta} - {geom.ceta[ETA_W-1], geom.ceta};
  end

  always_comb begin
    dphi_diff = $signed({1'b0, tphi_w_r}) - $signed({1'b0, geom.cphi_w});
    dphi_mag  = dphi_diff[PHI_W] ? -dphi_diff : dphi_diff;
    dphi_abs  = dphi_mag[PHI_W-1:0];
    // fold to the short way around
    if (dphi_abs > PHI_W'(PI_FX)) begin
      dphi_fold = PHI_W'(TWO_PI_FX) - dphi_abs;
    end else begin
      dphi_fold = dphi_abs;
    end
  end

  assign deta_prod = deta2_r * deta2_r;

  always_comb begin
    dr2 = {1'b0, deta_sq_r} + DR2_W'(dphi_sq_r);
    hit = (dr2 < DR2_W'(geom.outer_sq)) && (dr2 >= DR2_W'(geom.inner_sq));
    push           = v3_r;
    push_item.had  = hit ? it3_r.had : '0;
    push_item.em   = hit ? it3_r.em : '0;
    push_item.last = it3_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    tphi_w_r     <= tphi_wrap[PHI_W-1:0];
    deta1_r      <= deta;
    it1_r.had    <= had_et[ENERGY_WIDTH-1:0];
    it1_r.em     <= em_et[ENERGY_WIDTH-1:0];
    it1_r.last   <= last_tower;
    dphi_r       <= dphi_fold[DPHI_W-1:0];
    deta2_r      <= deta1_r;
    it2_r        <= it1_r;
    deta_sq_r    <= deta_prod[DETA_SQ_W-1:0];
    dphi_sq_r    <= dphi_r * dphi_r;
    it3_r        <= it2_r;
  end

endmodule

FILE: hw/rtl/acis_fifo.sv
// short queue of classified towers between classifier and accumulator
module acis_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  acis_pkg::acis_item_t         push_item,
  input  logic                         pop,
  output acis_pkg::acis_item_t         head,
  output logic                         empty,
  output logic [acis_pkg::FIFO_CW-1:0] count
);
  import acis_pkg::*;

  acis_item_t         mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hw/rtl/acis_div.sv
// one ratio lane: restoring divider, one quotient bit per cycle while step is set, saturating
module acis_div (
  input  logic                          clk,
  input  acis_pkg::acis_div_ctl_t       ctl,
  input  logic [acis_pkg::SUM_W-1:0]    sum,
  input  logic [acis_pkg::PT_W-1:0]     pt,
  output logic [acis_pkg::RATIO_W-1:0]  ratio
);
  import acis_pkg::*;

  logic [PT_W-1:0]    rem_r;
  logic [RATIO_W-1:0] dq_r;
  logic               sat_r;

  logic [PT_W:0]      trial;
  logic [PT_W:0]      diff;
  logic               ge;

  assign trial = {rem_r, dq_r[RATIO_W-1]};
  assign diff  = trial - {1'b0, pt};
  assign ge    = trial >= {1'b0, pt};
  assign ratio = sat_r ? '1 : dq_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      // quotient would not fit in the ratio width, also covers pt of zero
      sat_r <= (SUM_W + 1)'(sum) >= ((SUM_W + 1)'(pt) << RQ_SHIFT);
      rem_r <= PT_W'(sum >> RQ_SHIFT);
      dq_r  <= {sum[RQ_SHIFT-1:0], {RATIO_FRAC{1'b0}}};
    end else if (ctl.step) begin
      rem_r <= ge ? diff[PT_W-1:0] : trial[PT_W-1:0];
      dq_r  <= {dq_r[RATIO_W-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/acis_back.sv
// accumulator, end-of-pass divide and result register
module acis_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  acis_pkg::acis_item_t               head,
  input  logic                               empty,
  output logic                               pop,
  input  logic [acis_pkg::PT_W-1:0]          electron_pt,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [acis_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser
);
  import acis_pkg::*;

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [SUM_W-1:0]    had_acc_r, had_acc_nxt;
  logic [SUM_W-1:0]    em_acc_r, em_acc_nxt;
  logic [SUM_W-1:0]    had_tot_r, em_tot_r;
  logic [DIV_CW-1:0]   cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_SUM_W-1:0] out_had_sum_r, out_em_sum_r;
  logic [RATIO_W-1:0]  out_had_ratio_r, out_em_ratio_r;
  logic                out_pt_zero_r;

  logic [SUM_W:0]      had_add, em_add;
  logic [SUM_W-1:0]    had_sat, em_sat;
  logic                load_out;
  logic                close_pass;
  acis_div_ctl_t       div_ctl;
  logic [RATIO_W-1:0]  had_ratio, em_ratio;

  always_comb begin
    had_add = {1'b0, had_acc_r} + (SUM_W + 1)'(head.had);
    em_add  = {1'b0, em_acc_r} + (SUM_W + 1)'(head.em);
    had_sat = had_add[SUM_W] ? '1 : had_add[SUM_W-1:0];
    em_sat  = em_add[SUM_W] ? '1 : em_add[SUM_W-1:0];
  end

  assign pop        = (state_r == ST_ACC) && !empty;
  assign close_pass = pop && head.last;
  assign load_out   = (state_r == ST_HOLD) && (!out_valid_r || out_tready);
  assign div_ctl.load = close_pass;
  assign div_ctl.step = (state_r == ST_DIV);

  acis_div u_div_had (
    .clk   (clk),
    .ctl   (div_ctl),
    .sum   (had_sat),
    .pt    (electron_pt),
    .ratio (had_ratio)
  );

  acis_div u_div_em (
    .clk   (clk),
    .ctl   (div_ctl),
    .sum   (em_sat),
    .pt    (electron_pt),
    .ratio (em_ratio)
  );

  always_comb begin
    state_nxt   = state_r;
    had_acc_nxt = had_acc_r;
    em_acc_nxt  = em_acc_r;
    cnt_nxt     = cnt_r;
    unique case (state_r)
      ST_ACC: begin
        if (pop) begin
          if (head.last) begin
            had_acc_nxt = '0;
            em_acc_nxt  = '0;
            cnt_nxt     = '0;
            state_nxt   = ST_DIV;
          end else begin
            had_acc_nxt = had_sat;
            em_acc_nxt  = em_sat;
          end
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (load_out) begin
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      had_acc_r   <= '0;
      em_acc_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      had_acc_r   <= had_acc_nxt;
      em_acc_r    <= em_acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (close_pass) begin
      had_tot_r <= had_sat;
      em_tot_r  <= em_sat;
    end
    if (load_out) begin
      out_had_sum_r   <= OUT_SUM_W'(had_tot_r);
      out_em_sum_r    <= OUT_SUM_W'(em_tot_r);
      out_had_ratio_r <= had_ratio;
      out_em_ratio_r  <= em_ratio;
      out_pt_zero_r   <= (electron_pt == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_em_ratio_r, out_had_ratio_r, out_em_sum_r, out_had_sum_r};
  assign out_tuser  = out_pt_zero_r;

endmodule

FILE: hw/rtl/acis_checker.sv
// port-level checks on the result channel, bound to the top level
module acis_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [acis_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tuser
);
  import acis_pkg::*;

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // zero momentum saturates both ratios
  a_pt_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[79:56] == '1) && (out_tdata[103:80] == '1))
    else $error("pt zero without saturated ratios");

  // an empty sum gives a zero ratio when momentum is set
  a_zero_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && (out_tdata[27:0] == '0) && (out_tdata[55:28] == '0)
    |-> (out_tdata[79:56] == '0) && (out_tdata[103:80] == '0))
    else $error("nonzero ratio from zero sum");

endmodule

bind annulus_cone_isolation_sum_unit acis_checker u_acis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
